FILE: hdl/bae_pkg.sv
// Shared types and constants for the binary arithmetic encoder.
`default_nettype none

package bae_pkg;

   localparam int unsigned PROB_W      = 12;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned BOUND_W     = 32;
   localparam int unsigned BYTE_CNT_W  = 3;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic                   ACTION_CODE  = 1'b0;
   localparam logic                   ACTION_FLUSH = 1'b1;

   localparam logic [PROB_W-1:0]      HALF_PROB  = 12'd2048;
   localparam logic [BOUND_W-1:0]     FULL_HIGH  = 32'hffff_ffff;
   localparam logic [BOUND_W-1:0]     ZERO_LOW   = 32'h0000_0000;
   localparam logic [BYTE_W-1:0]      FILL_BYTE  = 8'hff;
   localparam logic [BYTE_W-1:0]      ZERO_BYTE  = 8'h00;
   localparam logic [BYTE_CNT_W-1:0]  MAX_BYTES  = 3'd4;
   localparam logic [BYTE_CNT_W-1:0]  LAST_SLOT  = 3'd3;

   // One classified request as it sits in the queue.
   typedef struct packed {
      logic              is_flush;
      logic              bit_value;
      logic [PROB_W-1:0] prob;
   } item_type;

   // Status of the coding engine, watched by the top level.
   typedef struct packed {
      logic                  busy;
      logic [BYTE_CNT_W-1:0] byte_cnt;
   } back_status_type;

endpackage

`default_nettype wire

FILE: hdl/bae_req_if.sv
// Request channel: one action, one bit and its probability.
`default_nettype none

interface bae_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic                         bit_value;
   logic [bae_pkg::PROB_W-1:0]   prob_one;

   modport source (output valid, output action, output bit_value, output prob_one,
                   input ready);
   modport sink   (input valid, input action, input bit_value, input prob_one,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/bae_rsp_if.sv
// Result channel: one compressed byte and its end marker.
`default_nettype none

interface bae_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bae_pkg::BYTE_W-1:0]   out_byte;
   logic                         last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bae_front.sv
// Front end: accepts requests, adjusts the probability and queues them.
`default_nettype none

module bae_front #(
   parameter int unsigned Depth = bae_pkg::QUEUE_DEPTH,
   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int unsigned CntW = $clog2(Depth + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   bae_req_if.sink                req_chan,
   output bae_pkg::item_type      item,
   output logic                   item_valid,
   input  wire logic              item_ready,
   output logic [CntW-1:0]        q_count
);

   bae_pkg::item_type  queue_ff [Depth];
   bae_pkg::item_type  new_item;
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push, pop;

   // Probabilities in the lower half are raised by one so zero never occurs.
   always_comb begin
      new_item.is_flush  = (req_chan.action == bae_pkg::ACTION_FLUSH);
      new_item.bit_value = req_chan.bit_value;
      if (req_chan.prob_one < bae_pkg::HALF_PROB) begin
         new_item.prob = req_chan.prob_one + 1'b1;
      end else begin
         new_item.prob = req_chan.prob_one;
      end
   end

   assign req_chan.ready = (count_ff != CntW'(Depth));
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign pop            = item_valid && item_ready;
   assign item           = queue_ff[rd_ptr_ff];
   assign q_count        = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bae_back.sv
// Back end: interval split, bound update and byte renormalization.
`default_nettype none

module bae_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bae_pkg::item_type     item,
   input  wire logic                  item_valid,
   output logic                       item_ready,
   bae_rsp_if.source                  rsp_chan,
   output bae_pkg::back_status_type   status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                            state_ff, state_in;
   logic [bae_pkg::BOUND_W-1:0]           low_ff, low_in;
   logic [bae_pkg::BOUND_W-1:0]           high_ff, high_in;
   logic [bae_pkg::BOUND_W-1:0]           hi_prod_ff, hi_prod_in;
   logic [23:0]                           lo_prod_ff, lo_prod_in;
   logic                                  bit_ff, bit_in;
   logic [bae_pkg::BYTE_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [bae_pkg::BYTE_W-1:0]            rsp_byte_ff, rsp_byte_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic [bae_pkg::BOUND_W-1:0]           span;
   logic [bae_pkg::BOUND_W-1:0]           mid;
   logic                                  out_free;
   logic                                  emit;
   logic                                  last_byte;

   assign span     = high_ff - low_ff;
   assign mid      = low_ff + hi_prod_ff + {20'd0, lo_prod_ff[23:12]};
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = (low_ff[31:24] == high_ff[31:24]) && (cnt_ff < bae_pkg::MAX_BYTES);
   // The byte going out is the last one when the next pair of top bytes differs
   // or the four-byte cap is reached.
   assign last_byte = (low_ff[23:16] != high_ff[23:16]) || (cnt_ff == bae_pkg::LAST_SLOT);

   assign item_ready = (state_ff == ST_IDLE) && (!item.is_flush || out_free);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;

   assign status.busy     = (state_ff != ST_IDLE);
   assign status.byte_cnt = cnt_ff;

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      hi_prod_in   = hi_prod_ff;
      lo_prod_in   = lo_prod_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && item_ready) begin
               if (item.is_flush) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = high_ff[31:24];
                  rsp_last_in  = 1'b1;
                  low_in       = bae_pkg::ZERO_LOW;
                  high_in      = bae_pkg::FULL_HIGH;
               end else begin
                  hi_prod_in = 32'(span[31:12]) * 32'(item.prob);
                  lo_prod_in = 24'(span[11:0]) * 24'(item.prob);
                  bit_in     = item.bit_value;
                  state_in   = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            if (bit_ff) begin
               high_in = mid;
            end else begin
               low_in = mid + 1'b1;
            end
            cnt_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = high_ff[31:24];
               rsp_last_in  = last_byte;
               low_in       = {low_ff[23:0], bae_pkg::ZERO_BYTE};
               high_in      = {high_ff[23:0], bae_pkg::FILL_BYTE};
               cnt_in       = cnt_ff + 1'b1;
               if (last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= bae_pkg::ZERO_LOW;
         high_ff      <= bae_pkg::FULL_HIGH;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_prod_ff  <= hi_prod_in;
      lo_prod_ff  <= lo_prod_in;
      bit_ff      <= bit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: hdl/binary_arithmetic_encoder_top.sv
// A code request passes the idle (multiply), update and emit states before its first byte
// reaches the result register; a flush loads its byte there straight from idle. A code
// request emits 0 to 4 bytes before the coding engine returns to idle.
// Renormalization emits one byte per cycle while the result channel is not stalled.
// Reset (synchronous, active high) empties the request queue and returns the interval
// to low = 0, high = 0xffffffff.
`default_nettype none

module binary_arithmetic_encoder_top #(
   parameter int unsigned QueueDepth = bae_pkg::QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bae_req_if.sink     req_chan,
   bae_rsp_if.source   rsp_chan
);

   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   // The front end takes each request into a short queue, so requests keep
   // arriving while the coding engine drains a burst of bytes.
   bae_pkg::item_type          item;
   logic                       item_valid;
   logic                       item_ready;
   logic [CntW-1:0]            q_count;
   bae_pkg::back_status_type   back_status;

   bae_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .q_count    (q_count)
   );

   // The back end splits the interval, updates the bounds and then shifts out up to four
   // settled top bytes through a registered result stage; a flush sends one last byte.
   bae_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .rsp_chan   (rsp_chan),
      .status     (back_status)
   );

   // The queue never holds more entries than it has room for.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CntW'(QueueDepth))
      else $error("request queue count exceeds its depth");

   // A full queue refuses new requests.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (q_count == CntW'(QueueDepth)) |-> !req_chan.ready)
      else $error("request accepted while the queue is full");

   // Renormalization never emits more than four bytes for one request.
   a_byte_cap: assert property (@(posedge clock) disable iff (reset)
      back_status.byte_cnt <= bae_pkg::MAX_BYTES)
      else $error("byte count of one request exceeds four");

   // While the engine works on a code request, it takes nothing from the queue.
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !item_ready)
      else $error("queue popped while the coding engine is busy");

endmodule

`default_nettype wire
